FILE: sv/mwa_pkg.sv
//------------------------------------------------------------------------------
// mwa_pkg
// Shared types and constants of the maximum window average block.
//------------------------------------------------------------------------------
`default_nettype none

package mwa_pkg;

  localparam int WINDOW_MAX_DEF = 1024;
  localparam int SAMPLE_W       = 16;
  localparam int FRAC_W         = 8;
  localparam int OUT_SUM_W      = 26;
  localparam int AVG_W          = 24;
  localparam int CFG_LEN_W      = 11;
  localparam int CFG_DATA_W     = 32;
  localparam int CFG_ADDR_W     = 3;
  localparam int CFG_IDX_W      = 1;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 1'b0;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } mwa_in_t;

  typedef struct packed {
    logic signed [OUT_SUM_W-1:0] best_sum;
    logic signed [AVG_W-1:0]     best_average;
    logic                        short_flag;
  } mwa_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_SUB,
    ST_CMP,
    ST_ABS,
    ST_DIV,
    ST_NEG,
    ST_OUT
  } mwa_state_t;

endpackage

`default_nettype wire

FILE: sv/max_window_average_top.sv
//------------------------------------------------------------------------------
// max_window_average_top
// Best sliding-window sum and its fixed-point average over a sample sequence.
//------------------------------------------------------------------------------
// Usage:
//   in channel (in_valid/in_ready/in_data) carries one signed sample a beat,
//   with a last mark on the final sample of a sequence. The out channel
//   (out_valid/out_ready/out_data) carries one result per sequence: best
//   window sum, its average with 8 fraction bits, and a short flag.
//   window_len is written through the APB port at byte address 0.
// Steps:
//   every sample passes accept with ring read, add, subtract and compare, the
//   last three through one shared adder. A full last sample adds an abs step, a
//   restoring divide of SUM_W+8 one-bit steps on the same adder, a negate step
//   and the output load; a short sequence goes from compare straight to the
//   output load.
// Reset:
//   window_len returns to 1 and the sequence state clears; the sample ring is
//   not cleared. A window_len write also restarts the sequence.
// Stall:
//   the result waits in the output register; the next sample is accepted
//   meanwhile, and a following last sample holds in its output step until the
//   register is free.
//------------------------------------------------------------------------------
`default_nettype none

module max_window_average_top
  import mwa_pkg::*;
#(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire mwa_in_t               in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output mwa_out_t                   out_data,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int PTR_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int LEN_W  = $clog2(WINDOW_MAX + 1);
  localparam int SUM_W  = SAMPLE_W + LEN_W;
  localparam int DVD_W  = SUM_W + FRAC_W;
  localparam int ALU_A  = (SUM_W + 1 > LEN_W + 2) ? SUM_W + 1 : LEN_W + 2;
  localparam int ALU_W  = (ALU_A > AVG_W + 1) ? ALU_A : AVG_W + 1;
  localparam int CNT_W  = $clog2(DVD_W + 1);
  localparam int IDX_W  = LEN_W + 1;

  mwa_state_t state_r, state_nxt;

  logic [CFG_LEN_W-1:0]       window_len_r;
  logic [LEN_W-1:0]           len_eff_r;
  logic [PTR_W-1:0]           wp_r;
  logic [LEN_W-1:0]           count_r;
  logic signed [SUM_W-1:0]    sum_r;
  logic signed [SUM_W-1:0]    best_r;
  logic signed [SAMPLE_W-1:0] sample_r;
  logic signed [SAMPLE_W-1:0] old_r;
  logic                       last_r;
  logic                       fill_r;
  logic                       short_r;
  logic                       neg_r;
  logic [LEN_W-1:0]           rem_r;
  logic [DVD_W-1:0]           quo_r;
  logic [CNT_W-1:0]           div_cnt_r;
  logic signed [AVG_W-1:0]    avg_r;
  logic                       out_valid_r;
  mwa_out_t                   out_data_r;

  logic signed [SAMPLE_W-1:0] ring [WINDOW_MAX];

  logic signed [ALU_W-1:0] alu_a, alu_b, alu_res;
  logic                    alu_sub;
  logic                    in_fire, cfg_wr, out_free;
  logic [IDX_W-1:0]        wp_ext, len_ext, idx_ext;
  logic [PTR_W-1:0]        old_idx;
  logic [CFG_LEN_W-1:0]    wr_len;
  logic [LEN_W-1:0]        wr_len_eff;
  logic [SUM_W-1:0]        best_mag;

  assign in_fire  = in_valid && in_ready;
  assign cfg_wr   = psel && penable && pwrite && pready &&
                    (paddr[CFG_ADDR_W-1:2] == REG_WINDOW_LEN);
  assign out_free = !out_valid_r || out_ready;
  assign pready   = 1'b1;
  assign prdata   = (paddr[CFG_ADDR_W-1:2] == REG_WINDOW_LEN) ?
                    CFG_DATA_W'(window_len_r) : '0;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // effective window length on write
  assign wr_len = pwdata[CFG_LEN_W-1:0];
  always_comb begin
    priority if (wr_len == '0) begin
      wr_len_eff = LEN_W'(1);
    end else if (32'(wr_len) > 32'(WINDOW_MAX)) begin
      wr_len_eff = LEN_W'(WINDOW_MAX);
    end else begin
      wr_len_eff = LEN_W'(wr_len);
    end
  end

  // slot of the sample leaving the window
  assign wp_ext  = IDX_W'(wp_r);
  assign len_ext = IDX_W'(len_eff_r);
  always_comb begin
    if (wp_ext >= len_ext) begin
      idx_ext = wp_ext - len_ext;
    end else begin
      idx_ext = wp_ext + IDX_W'(WINDOW_MAX) - len_ext;
    end
  end
  assign old_idx = PTR_W'(idx_ext);

  // shared adder
  assign alu_res = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_fire) state_nxt = ST_ADD;
      ST_ADD:  state_nxt = ST_SUB;
      ST_SUB:  state_nxt = ST_CMP;
      ST_CMP: begin
        if (!last_r) begin
          state_nxt = ST_IDLE;
        end else if (count_r < len_eff_r) begin
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_ABS;
        end
      end
      ST_ABS:  state_nxt = ST_DIV;
      ST_DIV:  if (div_cnt_r == CNT_W'(DVD_W - 1)) state_nxt = ST_NEG;
      ST_NEG:  state_nxt = ST_OUT;
      ST_OUT:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    alu_a    = '0;
    alu_b    = '0;
    alu_sub  = 1'b0;
    unique case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_ADD: begin
        alu_a = ALU_W'(sum_r);
        alu_b = ALU_W'(sample_r);
      end
      ST_SUB: begin
        alu_a   = ALU_W'(sum_r);
        alu_b   = fill_r ? '0 : ALU_W'(old_r);
        alu_sub = 1'b1;
      end
      ST_CMP: begin
        alu_a   = ALU_W'(sum_r);
        alu_b   = ALU_W'(best_r);
        alu_sub = 1'b1;
      end
      ST_ABS: begin
        alu_b   = ALU_W'(best_r);
        alu_sub = 1'b1;
      end
      ST_DIV: begin
        alu_a   = $signed(ALU_W'({rem_r, quo_r[DVD_W-1]}));
        alu_b   = $signed(ALU_W'(len_eff_r));
        alu_sub = 1'b1;
      end
      ST_NEG: begin
        alu_b   = $signed(quo_r[ALU_W-1:0]);
        alu_sub = 1'b1;
      end
      ST_OUT: ;
      default: ;
    endcase
  end

  assign best_mag = best_r[SUM_W-1] ? SUM_W'(alu_res) : best_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      window_len_r <= CFG_LEN_W'(1);
      len_eff_r    <= LEN_W'(1);
      wp_r         <= '0;
      count_r      <= '0;
      sum_r        <= '0;
      best_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_ready && (state_r != ST_OUT)) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr) begin
        window_len_r <= wr_len;
        len_eff_r    <= wr_len_eff;
        wp_r         <= '0;
        count_r      <= '0;
        sum_r        <= '0;
        best_r       <= '0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            sample_r <= in_data.sample;
            last_r   <= in_data.last;
            fill_r   <= (count_r < len_eff_r);
            wp_r     <= (wp_r == PTR_W'(WINDOW_MAX - 1)) ? '0 : wp_r + PTR_W'(1);
          end
        end
        ST_ADD: begin
          sum_r <= SUM_W'(alu_res);
          if (fill_r) count_r <= count_r + LEN_W'(1);
        end
        ST_SUB: sum_r <= SUM_W'(alu_res);
        ST_CMP: begin
          short_r <= (count_r < len_eff_r);
          if (fill_r) begin
            if (count_r == len_eff_r) best_r <= sum_r;
          end else if (alu_res > 0) begin
            best_r <= sum_r;
          end
        end
        ST_ABS: begin
          neg_r     <= best_r[SUM_W-1];
          quo_r     <= DVD_W'({best_mag, FRAC_W'(0)});
          rem_r     <= '0;
          div_cnt_r <= '0;
        end
        ST_DIV: begin
          if (!alu_res[ALU_W-1]) begin
            rem_r <= LEN_W'(alu_res);
            quo_r <= {quo_r[DVD_W-2:0], 1'b1};
          end else begin
            rem_r <= LEN_W'({rem_r, quo_r[DVD_W-1]});
            quo_r <= {quo_r[DVD_W-2:0], 1'b0};
          end
          div_cnt_r <= div_cnt_r + CNT_W'(1);
        end
        ST_NEG: avg_r <= neg_r ? AVG_W'(alu_res) : AVG_W'(quo_r);
        ST_OUT: begin
          if (out_free) begin
            out_valid_r             <= 1'b1;
            out_data_r.best_sum     <= short_r ? '0 : OUT_SUM_W'(best_r);
            out_data_r.best_average <= short_r ? '0 : avg_r;
            out_data_r.short_flag   <= short_r;
            wp_r    <= '0;
            count_r <= '0;
            sum_r   <= '0;
            best_r  <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // sample ring, read before write on the same slot
  always_ff @(posedge clk) begin
    if (in_fire) begin
      ring[wp_r] <= in_data.sample;
      old_r      <= ring[old_idx];
    end
  end

endmodule

`default_nettype wire

FILE: sv/mwa_checker.sv
//------------------------------------------------------------------------------
// mwa_checker
// Port-level checks of the maximum window average block, bound to the top.
//------------------------------------------------------------------------------
`default_nettype none

module mwa_checker
  import mwa_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     in_valid,
  input wire logic     in_ready,
  input wire logic     out_valid,
  input wire logic     out_ready,
  input wire mwa_out_t out_data
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat present after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("sample accepted while previous one still in work");

  a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.short_flag |->
      (out_data.best_sum == '0) && (out_data.best_average == '0))
    else $error("short result carries nonzero sum or average");

  a_avg_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.short_flag && !out_data.best_sum[OUT_SUM_W-1] |->
      !out_data.best_average[AVG_W-1])
    else $error("average sign disagrees with sum");

endmodule

bind max_window_average_top mwa_checker u_mwa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

FILE: test/max_window_average_top_test.sv
//------------------------------------------------------------------------------
// max_window_average_top_test
// Self-checking bench for the best sliding-window sum and average block.
// Streams sample sequences through the valid/ready input, predicts each
// sequence result in a scoreboard that mirrors the window ring and sums, and
// checks every result beat field by field. Covers field extremes, short
// sequences, clamped window lengths, a window_len write mid-sequence and
// random sequences under three sender/receiver idling mixes.
//------------------------------------------------------------------------------
`default_nettype none

module max_window_average_top_test;
  import mwa_pkg::*;

  localparam int SETTLE_CYCLES = 64;
  localparam int QUIET_LIMIT   = 5000;
  localparam int REPORT_MAX    = 10;

  class best_window_tracker;
    logic [CFG_LEN_W-1:0]       window_len;
    logic signed [SAMPLE_W-1:0] ring [WINDOW_MAX_DEF];
    int unsigned                wr_ptr;
    int unsigned                fill_count;
    longint                     win_sum;
    longint                     best_sum;
    mwa_out_t                   pending_results[$];
    int                         mismatch_count;

    function new();
      window_len     = 1;
      mismatch_count = 0;
      restart();
    endfunction

    function void restart();
      wr_ptr     = 0;
      fill_count = 0;
      win_sum    = 0;
      best_sum   = 0;
    endfunction

    function void set_len(logic [CFG_DATA_W-1:0] value);
      window_len = value[CFG_LEN_W-1:0];
      restart();
    endfunction

    function int unsigned active_len();
      if (window_len == 0) return 1;
      if (window_len > WINDOW_MAX_DEF) return WINDOW_MAX_DEF;
      return window_len;
    endfunction

    function void note_sample(mwa_in_t beat);
      int unsigned len;
      int unsigned old_idx;
      longint      avg;
      mwa_out_t    res;
      len = active_len();
      if (fill_count < len) begin
        win_sum += longint'(beat.sample);
        fill_count++;
        if (fill_count == len) best_sum = win_sum;
      end else begin
        old_idx = (wr_ptr + WINDOW_MAX_DEF - len) % WINDOW_MAX_DEF;
        win_sum += longint'(beat.sample) - longint'(ring[old_idx]);
        if (win_sum > best_sum) best_sum = win_sum;
      end
      ring[wr_ptr] = beat.sample;
      wr_ptr = (wr_ptr + 1) % WINDOW_MAX_DEF;
      if (beat.last) begin
        res = '0;
        if (fill_count < len) begin
          res.short_flag = 1'b1;
        end else begin
          avg = (best_sum * 256) / longint'(len);
          res.best_sum     = best_sum[OUT_SUM_W-1:0];
          res.best_average = avg[AVG_W-1:0];
        end
        pending_results.push_back(res);
        restart();
      end
    endfunction

    function void check_result(mwa_out_t got);
      mwa_out_t want;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("unexpected result beat: sum %0d avg %0d short %0b",
                   got.best_sum, got.best_average, got.short_flag);
        return;
      end
      want = pending_results.pop_front();
      if (got.best_sum !== want.best_sum || got.best_average !== want.best_average ||
          got.short_flag !== want.short_flag) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("result mismatch: expected sum %0d avg %0d short %0b, got %0d %0d %0b",
                   want.best_sum, want.best_average, want.short_flag,
                   got.best_sum, got.best_average, got.short_flag);
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  mwa_in_t               in_data;
  logic                  out_valid;
  logic                  out_ready;
  mwa_out_t              out_data;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  best_window_tracker tracker;
  int                 tx_idle_pct;
  int                 rx_idle_pct;
  int                 quiet_cycles = 0;

  max_window_average_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) tracker.check_result(out_data);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("[max_window_average_top] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_beat(input logic signed [SAMPLE_W-1:0] sample, input logic last);
    mwa_in_t beat;
    beat.sample = sample;
    beat.last   = last;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.note_sample(beat);
  endtask

  // one sequence of n samples, last mark on the final one
  task automatic send_run(input int n, input bit fixed, input logic signed [SAMPLE_W-1:0] value);
    logic signed [SAMPLE_W-1:0] s;
    for (int k = 0; k < n; k++) begin
      if (fixed) begin
        s = value;
      end else begin
        case ($urandom_range(9))
          0:       s = 16'sh7fff;
          1:       s = 16'sh8000;
          2, 3:    s = SAMPLE_W'($urandom_range(200)) - 16'sd100;
          default: s = SAMPLE_W'($urandom);
        endcase
      end
      send_beat(s, k == n - 1);
    end
  endtask

  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_window_len(input logic [CFG_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_WINDOW_LEN, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    tracker.set_len(value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    int sent;
    int seq_n;
    int unsigned len;
    tx_idle_pct = 30;
    rx_idle_pct = 48;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    tracker = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset window of one sample
    send_beat(16'sh7fff, 1'b1);
    send_beat(16'sh8000, 1'b1);
    send_beat(16'sd0, 1'b1);
    send_beat(16'sd5, 1'b0);
    send_beat(-16'sd3, 1'b0);
    send_beat(16'sd7, 1'b1);
    // zero length acts as one
    wait_quiet();
    write_window_len(32'd0);
    send_beat(16'sd100, 1'b0);
    send_beat(-16'sd1, 1'b1);
    // short sequence, negative average truncation, sliding update
    wait_quiet();
    write_window_len(32'd3);
    send_beat(16'sd1, 1'b0);
    send_beat(16'sd2, 1'b1);
    send_beat(-16'sd1, 1'b0);
    send_beat(16'sd0, 1'b0);
    send_beat(16'sd0, 1'b1);
    send_beat(16'sd1, 1'b0);
    send_beat(16'sd2, 1'b0);
    send_beat(16'sd3, 1'b0);
    send_beat(-16'sd10, 1'b0);
    send_beat(16'sd20, 1'b1);
    // write in the middle of a sequence restarts it
    send_beat(16'sd7, 1'b0);
    send_beat(16'sd8, 1'b0);
    wait_quiet();
    write_window_len(32'd2);
    send_beat(16'sd1, 1'b0);
    send_beat(16'sd2, 1'b1);

    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 4) begin
        tx_idle_pct = 48;
        rx_idle_pct = 30;
      end else if (ph == 8) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      wait_quiet();
      if (ph == 6) write_window_len(32'hffff_f801);
      else if ($urandom_range(9) < 6) write_window_len($urandom_range(1, 8));
      else write_window_len($urandom_range(9, 40));
      len  = tracker.active_len();
      sent = 0;
      while (sent < 12) begin
        case ($urandom_range(9))
          0:       seq_n = (len > 1) ? $urandom_range(1, len - 1) : 1;
          8, 9:    seq_n = $urandom_range(1, 3 * len);
          default: seq_n = len + $urandom_range(0, 2 * len + 4);
        endcase
        send_run(seq_n, 1'b0, '0);
        sent += seq_n;
      end
    end

    // widest window: bottom of the result range, then a short run
    wait_quiet();
    write_window_len(32'd2047);
    send_run(1026, 1'b1, 16'sh8000);
    send_run(5, 1'b1, 16'sh7fff);

    wait_quiet();
    if (tracker.mismatch_count == 0 && tracker.pending_results.size() == 0) begin
      $display("[max_window_average_top] OK");
    end else begin
      $display("[max_window_average_top] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
sv/mwa_pkg.sv
sv/max_window_average_top.sv
sv/mwa_checker.sv
test/max_window_average_top_test.sv
